/* rtl/gfci_pkg.sv */
// Shared constants, types and a helper function for the grid face child index block.
`default_nettype none
package gfci_pkg;
  localparam int MaxLevel = 8;
  localparam int LvW = 4;
  localparam int IdxW = 26;
  localparam int ChW = 29;
  localparam int CoW = 8;
  // Quotient bits of one divide; each cell retires QB of them.
  localparam int QW = 9;
  localparam int QB = 3;
  localparam int NDiv = QW / QB;
  // Slice divide cells followed by row divide cells.
  localparam int NCells = 2 * NDiv;
  localparam int LoW = 4;

  localparam logic [1:0] ORIENT_X = 2'd0;
  localparam logic [1:0] ORIENT_Y = 2'd1;
  localparam logic [1:0] ORIENT_Z = 2'd2;

  // Work word handed from cell to cell.
  typedef struct packed {
    logic            vld;
    logic [LvW-1:0]  lv;
    logic [IdxW-1:0] rem;
    logic [CoW-1:0]  s;
    logic [CoW-1:0]  r;
    logic [1:0]      orient;
    logic            oor;
  } work_t;

  // Faces in one slice: 3n^2 - 2n, level already saturated.
  function automatic logic [IdxW-1:0] slice_faces(input logic [LvW-1:0] lv);
    logic [IdxW-1:0] n;
    begin
      n = IdxW'(1) << lv;
      slice_faces = IdxW'(3) * (n << lv) - (n << 1);
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/gfci_cell.sv */
// One divide cell: retires QB quotient bits of the slice or the row of a face.
`default_nettype none
module gfci_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     stage,
  input  wire logic [gfci_pkg::LoW-1:0] lo,
  input  wire gfci_pkg::work_t          in,
  output gfci_pkg::work_t               out
);
  gfci_pkg::work_t nx;
  logic [gfci_pkg::IdxW-1:0] n, dv, rm, xy;
  logic [gfci_pkg::IdxW+gfci_pkg::QW-1:0] t;
  logic [gfci_pkg::QB-1:0] q;
  logic first, last;

  assign first = (lo == gfci_pkg::LoW'(gfci_pkg::QW - gfci_pkg::QB));
  assign last  = (lo == '0);

  always_comb begin
    nx = in;
    n  = gfci_pkg::IdxW'(1) << in.lv;
    xy = (n << (in.lv + 1)) - (n << 1);
    if (stage == 1'b0) dv = gfci_pkg::slice_faces(in.lv);
    else               dv = (n << 1) - 1'b1;
    rm = in.rem;
    q  = '0;
    t  = '0;
    if (stage == 1'b1 && in.orient == gfci_pkg::ORIENT_Z) begin
      // pass a finished z split through
      nx = in;
    end else if (stage == 1'b1 && first && rm >= xy) begin
      // z faces: row and column are a plain split by n
      nx.orient = gfci_pkg::ORIENT_Z;
      rm = rm - xy;
      nx.r = gfci_pkg::CoW'(rm >> in.lv);
      nx.rem = rm & (n - 1'b1);
    end else begin
      for (int j = gfci_pkg::QB - 1; j >= 0; j--) begin
        t = (gfci_pkg::IdxW+gfci_pkg::QW)'(dv) << (lo + gfci_pkg::LoW'(j));
        if ({{gfci_pkg::QW{1'b0}}, rm} >= t) begin
          rm = rm - gfci_pkg::IdxW'(t);
          q[j] = 1'b1;
        end
      end
      nx.rem = rm;
      if (stage == 1'b0) nx.s = gfci_pkg::CoW'({in.s, q});
      else begin
        nx.r = gfci_pkg::CoW'({in.r, q});
        if (last) begin
          if (rm < n - 1'b1) nx.orient = gfci_pkg::ORIENT_X;
          else begin
            nx.orient = gfci_pkg::ORIENT_Y;
            nx.rem = rm - (n - 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out.vld <= 1'b0;
    else if (en) begin
      out <= nx;
    end
  end
endmodule
`default_nettype wire

/* rtl/gfci_child.sv */
// Final cell: builds the four child indices from orientation, column, row and slice.
`default_nettype none
module gfci_child (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire gfci_pkg::work_t in,
  output logic                 vld,
  output logic [1:0]           orientation,
  output logic [7:0]           column,
  output logic [7:0]           row,
  output logic [7:0]           slice,
  output logic [28:0]          child_first,
  output logic [28:0]          child_second,
  output logic [28:0]          child_third,
  output logic [28:0]          child_fourth,
  output logic                 out_of_range
);
  localparam int W = gfci_pkg::ChW;
  logic [W-1:0] m, f, st, xy, c, r, s, b0, b1, k0, k1;
  logic [W-1:0] a0, a1, a2, a3;

  always_comb begin
    m  = W'(2) << in.lv;
    f  = W'(3) * (m << (in.lv + 1)) - (m << 1);
    st = (m << 1) - 1'b1;
    xy = (m << (in.lv + 2)) - (m << 1);
    c  = W'(in.rem[gfci_pkg::CoW-1:0]);
    r  = W'(in.r);
    s  = W'(in.s);
    b0 = (s << 1) * f;
    b1 = b0 + f;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0;
    k0 = '0; k1 = '0;
    case (in.orient)
      gfci_pkg::ORIENT_X: begin
        k0 = (r << 1) * st + (c << 1) + 1'b1;
        k1 = k0 + st;
        a0 = b0 + k0; a1 = b1 + k0; a2 = b0 + k1; a3 = b1 + k1;
      end
      gfci_pkg::ORIENT_Y: begin
        k0 = ((r << 1) + 1'b1) * st + (c << 1) + m - 1'b1;
        a0 = b0 + k0; a1 = b1 + k0; a2 = b0 + k0 + 1'b1; a3 = b1 + k0 + 1'b1;
      end
      default: begin
        k0 = b1 + xy + (r << 1) * m + (c << 1);
        a0 = k0; a1 = k0 + m; a2 = k0 + 1'b1; a3 = k0 + m + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else if (en) begin
      vld <= in.vld;
      out_of_range <= in.oor;
      orientation  <= in.oor ? gfci_pkg::ORIENT_X : in.orient;
      column       <= in.oor ? '0 : in.rem[gfci_pkg::CoW-1:0];
      row          <= in.oor ? '0 : in.r;
      slice        <= in.oor ? '0 : in.s;
      child_first  <= in.oor ? '0 : a0;
      child_second <= in.oor ? '0 : a1;
      child_third  <= in.oor ? '0 : a2;
      child_fourth <= in.oor ? '0 : a3;
    end
  end
endmodule
`default_nettype wire

/* rtl/grid_face_child_index.sv */
// Top level: grid face decode and child index pipeline.
// Each request is decoded into orientation, column, row and slice of a face in a cubic
// grid of 2^level boxes per side, and its four child face indices at level+1 are returned.
// The pipeline takes one request per cycle when it is not stalled. It has seven register
// stages: three slice divide cells, three row divide cells, each retiring three quotient
// bits, and the child build cell.
// Requests beyond the grid come back with out_of_range set and all other fields zero.
// Levels above eight act as eight. The whole pipeline stalls while the result is not taken.
`default_nettype none
module grid_face_child_index (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [25:0] face_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       orientation,
  output logic [7:0]       column,
  output logic [7:0]       row,
  output logic [7:0]       slice,
  output logic [28:0]      child_first,
  output logic [28:0]      child_second,
  output logic [28:0]      child_third,
  output logic [28:0]      child_fourth,
  output logic             out_of_range
);
  logic [3:0] level;
  logic [3:0] lv;
  logic en;
  gfci_pkg::work_t head;
  gfci_pkg::work_t w [gfci_pkg::NCells+1];
  logic [gfci_pkg::IdxW+8:0] tot;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) level <= '0;
    else if (cfg_valid) level <= cfg_data;
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign lv = (level > 4'(gfci_pkg::MaxLevel)) ? 4'(gfci_pkg::MaxLevel) : level;
  assign tot = (gfci_pkg::IdxW+9)'(gfci_pkg::slice_faces(lv)) << lv;

  always_comb begin
    head.vld = in_valid;
    head.lv = lv;
    head.rem = face_index;
    head.s = '0;
    head.r = '0;
    head.orient = gfci_pkg::ORIENT_X;
    head.oor = {9'd0, face_index} >= tot;
  end

  assign w[0] = head;

  for (genvar g = 0; g < gfci_pkg::NCells; g++) begin : g_cell
    gfci_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .stage(1'(g / gfci_pkg::NDiv)),
      .lo(4'(gfci_pkg::QW - gfci_pkg::QB * (g % gfci_pkg::NDiv + 1))),
      .in(w[g]), .out(w[g+1])
    );
  end

  gfci_child u_child (
    .clk(clk), .rst(rst), .en(en), .in(w[gfci_pkg::NCells]), .vld(out_valid),
    .orientation(orientation), .column(column), .row(row), .slice(slice),
    .child_first(child_first), .child_second(child_second),
    .child_third(child_third), .child_fourth(child_fourth),
    .out_of_range(out_of_range)
  );
endmodule
`default_nettype wire
